/* src/z85enc_pkg.sv */
// Shared types, constants and the Z85 alphabet lookup for the Z85 stream encoder.
package z85enc_pkg;

    localparam int unsigned RECIP_SHIFT = 38;
    localparam int unsigned PROD_W      = 64;
    localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

    // ceil(2^38 / 85): exact floor division by 85 for any 32-bit dividend
    localparam logic [31:0] RECIP85 = 32'hC0C0C0C1;
    localparam logic [6:0]  RADIX   = 7'd85;

    localparam logic [6:0] DIGIT_ALPHA_LO = 7'd10;
    localparam logic [6:0] DIGIT_ALPHA_UP = 7'd36;
    localparam logic [6:0] DIGIT_PUNCT    = 7'd62;

    localparam logic [6:0] Z85_PUNCT [23] = '{
        7'd46, 7'd45, 7'd58, 7'd43, 7'd61, 7'd94, 7'd33, 7'd47,
        7'd42, 7'd63, 7'd38, 7'd60, 7'd62, 7'd40, 7'd41, 7'd91,
        7'd93, 7'd123, 7'd125, 7'd64, 7'd37, 7'd36, 7'd35
    };

    typedef logic [6:0] digit_t;

    // one closed group: padded word and the number of characters it yields
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nchars;
    } group_t;

    // converted group: digit[0] is the most significant digit
    typedef struct packed {
        digit_t [4:0] digit;
        logic [2:0]   nchars;
    } digits_t;

    function automatic logic [6:0] z85_char(input digit_t d);
        logic [6:0] pidx;
        logic [6:0] ch;
        pidx = d - DIGIT_PUNCT;
        if (d < DIGIT_ALPHA_LO) begin
            ch = d + 7'd48;        // '0'..'9'
        end
        else if (d < DIGIT_ALPHA_UP) begin
            ch = d + 7'd87;        // 'a'..'z'
        end
        else if (d < DIGIT_PUNCT) begin
            ch = d + 7'd29;        // 'A'..'Z'
        end
        else if (d < RADIX) begin
            ch = Z85_PUNCT[pidx[4:0]];
        end
        else begin
            ch = 7'd0;
        end
        return ch;
    endfunction

endpackage

/* src/z85_byte_stream_encoder_top.sv */
// Top level of the Z85 byte stream encoder: packer, group queue, converter, emitter.
// Throughput: one byte per cycle in while the group queue has room. Each group goes
//   through the converter as 1 load + 5 reciprocal-multiply steps, a short final group
//   as well as a full one; the converter takes no new group until the last is done.
// Once a group reaches the emitter, characters leave at one per cycle while out_ready is high.
// Reset (rst_n, async, active low) empties the queue, drops partial groups and outputs.
module z85_byte_stream_encoder_top
    import z85enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [6:0] out_char,
    output logic       group_last,
    output logic       out_valid,
    input  logic       out_ready
);

    // front end -> queue
    group_t  pk_grp;
    logic    pk_valid;
    logic    pk_ready;

    // queue -> converter
    group_t  q_grp;
    logic    q_valid;
    logic    q_ready;

    // converter -> emitter
    digits_t cv_dig;
    logic    cv_valid;
    logic    cv_ready;

    // Packs bytes; a closing byte transfers a padded group into the queue.
    z85enc_pack u_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .grp           (pk_grp),
        .grp_valid     (pk_valid),
        .grp_ready     (pk_ready)
    );

    // Two groups of slack so the front end keeps taking bytes during conversion.
    z85enc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (pk_grp),
        .wr_valid (pk_valid),
        .wr_ready (pk_ready),
        .rd_data  (q_grp),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    // Splits the 32-bit word into five base-85 digits.
    z85enc_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (q_grp),
        .grp_valid (q_valid),
        .grp_ready (q_ready),
        .dig       (cv_dig),
        .dig_valid (cv_valid),
        .dig_ready (cv_ready)
    );

    // Maps digits through the alphabet; output register parts it from the consumer.
    z85enc_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .dig        (cv_dig),
        .dig_valid  (cv_valid),
        .dig_ready  (cv_ready),
        .out_char   (out_char),
        .group_last (group_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    // Every emitted character lies in the Z85 alphabet range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char >= 7'd33) && (out_char <= 7'd125))
        else $error("character outside Z85 alphabet range");

    // A byte marked end of stream always closes a group in the same transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && end_of_stream) |-> (pk_valid && pk_ready))
        else $error("end-of-stream byte did not close a group");

    // A group handed to the emitter is always followed by output pending on out_valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cv_valid && cv_ready) |=> ##1 out_valid)
        else $error("handed-off group produced no output");

endmodule

/* src/z85enc_pack.sv */
// Front end: packs bytes big-endian into groups and closes them with zero padding.
module z85enc_pack
    import z85enc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   data_byte,
    input  logic         end_of_stream,
    input  logic         in_valid,
    output logic         in_ready,
    output group_t       grp,
    output logic         grp_valid,
    input  logic         grp_ready
);

    logic [23:0] word_reg, word_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        accept;
    logic        close_grp;

    assign in_ready = grp_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        close_grp  = (cnt_reg == 2'd3) || end_of_stream;
        grp_valid  = accept && close_grp;
        word_next  = word_reg;
        cnt_next   = cnt_reg;
        grp.word   = {word_reg, data_byte};
        grp.nchars = 3'd5;
        case (cnt_reg)
            2'd0:
            begin
                grp.word   = {data_byte, 24'd0};
                grp.nchars = 3'd2;
            end
            2'd1:
            begin
                grp.word   = {word_reg[7:0], data_byte, 16'd0};
                grp.nchars = 3'd3;
            end
            2'd2:
            begin
                grp.word   = {word_reg[15:0], data_byte, 8'd0};
                grp.nchars = 3'd4;
            end
            default:
            begin
                grp.word   = {word_reg, data_byte};
                grp.nchars = 3'd5;
            end
        endcase
        if (accept) begin
            if (close_grp) begin
                word_next = 24'd0;
                cnt_next  = 2'd0;
            end
            else begin
                word_next = {word_reg[15:0], data_byte};
                cnt_next  = cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            word_reg <= 24'd0;
            cnt_reg  <= 2'd0;
        end
        else begin
            word_reg <= word_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* src/z85enc_queue.sv */
// Two-entry group queue between the front end and the converter.
module z85enc_queue
    import z85enc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  group_t wr_data,
    input  logic   wr_valid,
    output logic   wr_ready,
    output group_t rd_data,
    output logic   rd_valid,
    input  logic   rd_ready
);

    group_t      mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/z85enc_conv.sv */
// Base-85 converter: one reciprocal multiply per cycle, digits are produced least significant first.
module z85enc_conv
    import z85enc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  group_t  grp,
    input  logic    grp_valid,
    output logic    grp_ready,
    output digits_t dig,
    output logic    dig_valid,
    input  logic    dig_ready
);

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [31:0]       n_reg, n_next;
    digit_t [4:0]      digits_reg, digits_next;
    logic [2:0]        nchars_reg, nchars_next;
    logic [2:0]        step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              load;
    logic [QUOT_W-1:0] quot;
    logic [6:0]        qmul;
    digit_t            rem;
    logic [31:0]       mul_in;

    assign grp_ready  = !busy_reg && (!done_reg || dig_ready);
    assign load       = grp_valid && grp_ready;
    assign dig_valid  = done_reg;
    assign dig.digit  = digits_reg;
    assign dig.nchars = nchars_reg;

    always_comb
    begin
        quot = prod_reg[PROD_W-1:RECIP_SHIFT];
        // remainder is below 85, so 7-bit wraparound arithmetic is exact
        qmul = 7'(quot[6:0] * RADIX);
        rem  = n_reg[6:0] - qmul;

        mul_in      = load ? grp.word : 32'(quot);
        prod_next   = {32'd0, mul_in} * {32'd0, RECIP85};
        n_next      = mul_in;
        digits_next = digits_reg;
        nchars_next = nchars_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        done_next   = done_reg;

        if (load) begin
            nchars_next = grp.nchars;
            step_next   = 3'd0;
            busy_next   = 1'b1;
            done_next   = 1'b0;
        end
        else if (busy_reg) begin
            digits_next = {digits_reg[3:0], rem};
            if (step_reg == 3'd4) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else begin
                step_next = step_reg + 3'd1;
            end
        end
        else if (done_reg && dig_ready) begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        n_reg      <= n_next;
        digits_reg <= digits_next;
        nchars_reg <= nchars_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg <= 3'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

/* src/z85enc_emit.sv */
// Back end: holds a converted group and issues its characters, most significant first.
module z85enc_emit
    import z85enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  digits_t    dig,
    input  logic       dig_valid,
    output logic       dig_ready,
    output logic [6:0] out_char,
    output logic       group_last,
    output logic       out_valid,
    input  logic       out_ready
);

    digit_t     buf_reg [5];
    logic [2:0] idx_reg, idx_next;
    logic [2:0] nchars_reg, nchars_next;
    logic       active_reg, active_next;
    logic [6:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       valid_reg, valid_next;
    logic       advance;
    logic       at_last;
    logic       load;

    assign advance    = !valid_reg || out_ready;
    assign at_last    = (idx_reg == (nchars_reg - 3'd1));
    assign dig_ready  = !active_reg || (advance && at_last);
    assign load       = dig_valid && dig_ready;
    assign out_char   = char_reg;
    assign group_last = last_reg;
    assign out_valid  = valid_reg;

    always_comb
    begin
        idx_next    = idx_reg;
        nchars_next = nchars_reg;
        active_next = active_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        valid_next  = valid_reg;
        if (advance) begin
            if (active_reg) begin
                char_next  = z85_char(buf_reg[idx_reg]);
                last_next  = at_last;
                valid_next = 1'b1;
                idx_next   = idx_reg + 3'd1;
                if (at_last) begin
                    active_next = 1'b0;
                end
            end
            else begin
                valid_next = 1'b0;
            end
        end
        if (load) begin
            idx_next    = 3'd0;
            nchars_next = dig.nchars;
            active_next = 1'b1;
        end
    end

    // digit[0] is the most significant digit, so buf_reg[0] goes out first
    always_ff @(posedge clk)
    begin
        if (load) begin
            for (int i = 0; i < 5; i++) begin
                buf_reg[i] <= dig.digit[i];
            end
        end
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg    <= 3'd0;
            nchars_reg <= 3'd0;
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else begin
            idx_reg    <= idx_next;
            nchars_reg <= nchars_next;
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

endmodule

/* dv/z85_byte_stream_encoder_top_tb.sv */
// Self-checking testbench for the Z85 byte stream encoder top level.
module z85_byte_stream_encoder_top_tb;
    import z85enc_pkg::*;

    // Longest run of cycles with no transfer on either side before the run is declared hung.
    // The deliberate output hold-off is HOLD_OFF_CYCLES; random stalls come on top of it.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    // Cycles allowed after the last expected character has come out.
    localparam int DRAIN_CYCLES    = 24;

    // Expected-character store with its own model of the packer and base-85 converter.
    class z85_scoreboard;
        string       alphabet;
        logic [31:0] open_word;
        logic [1:0]  open_count;
        logic [6:0]  char_q[$];
        logic        last_q[$];
        int          errors;

        function new();
            alphabet   = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
            open_word  = '0;
            open_count = '0;
            errors     = 0;
        endfunction

        // Account for one accepted byte; a closing byte queues the group's characters.
        function void note_byte(input logic [7:0] b, input logic eos);
            logic [2:0]  held;
            logic [2:0]  pad;
            logic [2:0]  nchars;
            logic [31:0] word;
            logic [31:0] rest;
            logic [6:0]  digits[5];
            int          i;
            held = {1'b0, open_count} + 3'd1;
            word = {open_word[23:0], b};
            if (held < 3'd4 && !eos)
            begin
                open_word  = word;
                open_count = held[1:0];
                return;
            end
            // short final group: zero bytes fill the low end
            pad  = 3'd4 - held;
            word = word << {pad, 3'b000};
            rest = word;
            for (i = 4; i >= 0; i--)
            begin
                digits[i] = 7'(rest % 32'(RADIX));
                rest      = rest / 32'(RADIX);
            end
            nchars = 3'd5 - pad;
            for (i = 0; i < int'(nchars); i++)
            begin
                char_q.push_back(7'(alphabet[digits[i]]));
                last_q.push_back(i == int'(nchars) - 1);
            end
            open_word  = '0;
            open_count = '0;
        endfunction

        // Compare one accepted character against the oldest expectation.
        function void check_char(input logic [6:0] ch, input logic last);
            logic [6:0] exp_char;
            logic       exp_last;
            if (char_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected char %0d last %0b", $time, ch, last);
                return;
            end
            exp_char = char_q.pop_front();
            exp_last = last_q.pop_front();
            if (ch !== exp_char)
            begin
                errors++;
                $display("%0t: out_char expected %0d got %0d", $time, exp_char, ch);
            end
            if (last !== exp_last)
            begin
                errors++;
                $display("%0t: group_last expected %0b got %0b", $time, exp_last, last);
            end
        endfunction

        function int pending();
            return char_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic [7:0] data_byte;
    logic       end_of_stream;
    logic       in_valid;
    logic       in_ready;
    logic [6:0] out_char;
    logic       group_last;
    logic       out_valid;
    logic       out_ready;

    z85_scoreboard sb;

    // Idle rates in percent, changed between phases by the stimulus process.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Set by the stimulus process to ask the receiver for one long hold-off.
    bit hold_request   = 1'b0;

    z85_byte_stream_encoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .out_char      (out_char),
        .group_last    (group_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one byte, with random idle cycles ahead of it, and hold it until the transfer.
    // Called at a rising edge, so each edge sees a single update of in_valid.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_stream <= eos;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b, eos);
    endtask

    // Random bytes; end of stream marks are frequent enough to hit every short group size.
    task automatic send_random(input int count, input int eos_pct);
        int n;
        for (n = 0; n < count; n++)
        begin
            send_byte(8'($urandom_range(255)), $urandom_range(99) < eos_pct);
        end
    endtask

    // Stop offering and wait for every expected character to come out.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
        begin
            @(posedge clk);
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off counted here on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Output checker and watchdog: every character transfer is checked; the run
    // ends as a failure when the watchdog finds neither side moving anything.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                sb.check_char(out_char, group_last);
            end
            if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("z85_byte_stream_encoder_top: mismatch");
        $finish;
    end

    // Stimulus: directed groups, then random phases with different idle patterns.
    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        end_of_stream = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: all-zero full group (leading zero digits kept).
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        // All-ones group, end of stream on the fourth byte still gives five chars.
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Short final groups of one, two and three bytes.
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h55, 1'b1);
        // Full group right after a padded one: pad count must not carry over.
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        // Single zero byte stream.
        send_byte(8'h00, 1'b1);

        // Phase: no idling on either side.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(60, 20);

        // Phase: sender mostly idle; afterwards let the encoder empty completely.
        send_idle_pct = 70;
        send_random(60, 20);
        wait_for_drain();

        // Phase: receiver mostly stalling, including one long hold-off while the
        // sender keeps pushing, so the group queue fills and in_ready drops.
        send_idle_pct  = 0;
        recv_stall_pct = 70;
        hold_request   = 1'b1;
        send_random(40, 5);
        send_random(60, 20);

        // Phase: light idling on both sides.
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        send_random(40, 25);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("z85_byte_stream_encoder_top: match");
        end
        else
        begin
            $display("z85_byte_stream_encoder_top: mismatch");
        end
        $finish;
    end

endmodule
